### hdl/wrf_pkg.sv
// Package for the waveform run fold block: field widths, run limit and
// the request types of the line and fold channels. No dependencies.
package wrf_pkg;

  localparam int MaxRun    = 256;
  localparam int RunLenW   = $clog2(MaxRun + 2);
  localparam int SampleW   = 16;
  localparam int ColorW    = 8;
  localparam int FlagW     = 8;
  localparam int SumW      = 32;
  localparam int WeightW   = 24;
  localparam int NumColors = 3;
  localparam int ColorSelW = $clog2(NumColors);
  localparam int ProdW     = ColorW + SampleW;

  typedef struct packed {
    logic signed [SampleW-1:0] line_min;
    logic signed [SampleW-1:0] line_max;
    logic        [ColorW-1:0]  line_red;
    logic        [ColorW-1:0]  line_green;
    logic        [ColorW-1:0]  line_blue;
    logic        [FlagW-1:0]   line_flags;
    logic                      last_in_run;
  } line_t;

  typedef struct packed {
    logic signed [SampleW-1:0] fold_min;
    logic signed [SampleW-1:0] fold_max;
    logic        [ColorW-1:0]  fold_red;
    logic        [ColorW-1:0]  fold_green;
    logic        [ColorW-1:0]  fold_blue;
    logic        [FlagW-1:0]   fold_flags;
    logic                      overrun;
  } fold_t;

endpackage

### hdl/wrf_line_if.sv
// Valid/ready channel carrying one display line request.
// Depends on wrf_pkg.
interface wrf_line_if;
  import wrf_pkg::*;
  logic  valid;
  logic  ready;
  line_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/wrf_fold_if.sv
// Valid/ready channel carrying one folded line request.
// Depends on wrf_pkg.
interface wrf_fold_if;
  import wrf_pkg::*;
  logic  valid;
  logic  ready;
  fold_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/wrf_div.sv
// Restoring divider, one quotient bit per cycle; keeps the low quotient
// byte of a color sum over the weight sum. Depends on wrf_pkg.
module wrf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [wrf_pkg::SumW-1:0]    dividend_i,
  input  logic [wrf_pkg::WeightW-1:0] divisor_i,
  output logic                      done_o,
  output logic [wrf_pkg::ColorW-1:0]  quot_o
);
  import wrf_pkg::*;

  localparam int CntW = $clog2(SumW);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [SumW-1:0]    dvd_q;
  logic [WeightW-1:0] dvs_q;
  logic [WeightW-1:0] rem_q;
  logic [WeightW-1:0] rem_d;
  logic [ColorW-1:0]  quot_q;
  logic [WeightW:0]   trial;
  logic               fits;

  assign trial = {rem_q, dvd_q[SumW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign rem_d = fits ? WeightW'(trial - {1'b0, dvs_q}) : WeightW'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[SumW-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[ColorW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished pass");

  a_remainder_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && dvs_q != '0 |-> rem_q < dvs_q)
    else $error("divider remainder out of range");

endmodule

### hdl/waveform_run_fold.sv
// Top level of the waveform run fold block: run accumulation with one
// shared multiply-accumulate, and the final color division through wrf_div.
// Depends on wrf_pkg, wrf_line_if, wrf_fold_if and wrf_div.
//
//   channel   direction  handshake      request
//   line_i    in         valid/ready    line_t: min, max, rgb, flags, last
//   fold_o    out        valid/ready    fold_t: min, max, rgb, flags, overrun
//
// A line is accepted in StIdle, then StMac adds each color in turn on the
// single 8x16 multiply-accumulate. The last line of a run then passes each
// color through the bit-serial divider (one quotient bit per cycle) in StDiv,
// and StHold moves the result into the output register.
// rst_ni clears the run state and the output valid asynchronously.
// A stalled fold_o holds one finished run; the next run's lines keep being
// accepted until that run also finishes and waits in StHold.
module waveform_run_fold (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrf_line_if.sink   line_i,
  wrf_fold_if.source fold_o
);
  import wrf_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMac  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StHold = 2'd3;

  logic [1:0]                state_q;
  logic [ColorSelW-1:0]      sel_q;
  logic                      div_req_q;
  logic                      last_q;
  logic [SampleW-1:0]        w_q;
  logic [ColorW-1:0]         col_q [NumColors];
  logic [SumW-1:0]           sum_q [NumColors];
  logic [ColorW-1:0]         res_q [NumColors];
  logic [WeightW-1:0]        weight_q;
  logic [FlagW-1:0]          flags_q;
  logic                      started_q;
  logic [RunLenW-1:0]        run_len_q;
  logic signed [SampleW-1:0] run_min_q;
  logic signed [SampleW-1:0] run_max_q;
  fold_t                     fold_q;
  logic                      out_valid_q;

  logic               in_acc;
  logic               out_acc;
  logic               load_out;
  logic [SampleW-1:0] mag_lo;
  logic [SampleW-1:0] mag_hi;
  logic [SampleW-1:0] mag;
  logic [SampleW-1:0] w;
  logic [ProdW-1:0]   prod;
  logic               div_start;
  logic               div_done;
  logic [ColorW-1:0]  div_quot;
  line_t              ln;

  assign ln       = line_i.data;
  assign in_acc   = line_i.valid && line_i.ready;
  assign out_acc  = out_valid_q && fold_o.ready;
  assign load_out = (state_q == StHold) && (!out_valid_q || fold_o.ready);

  assign mag_lo = ln.line_min[SampleW-1] ? SampleW'(~ln.line_min + 1'b1) : ln.line_min;
  assign mag_hi = ln.line_max[SampleW-1] ? SampleW'(~ln.line_max + 1'b1) : ln.line_max;
  assign mag    = (mag_lo > mag_hi) ? mag_lo : mag_hi;
  assign w      = (mag == '0) ? SampleW'(1) : mag;

  assign prod      = col_q[sel_q] * w_q;
  assign div_start = (state_q == StDiv) && div_req_q;

  wrf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[sel_q]),
    .divisor_i  (weight_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= '0;
      div_req_q   <= 1'b0;
      weight_q    <= '0;
      flags_q     <= '1;
      started_q   <= 1'b0;
      run_len_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumColors; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            weight_q  <= weight_q + WeightW'(w);
            flags_q   <= flags_q & ln.line_flags;
            started_q <= 1'b1;
            if (run_len_q <= RunLenW'(MaxRun)) begin
              run_len_q <= run_len_q + RunLenW'(1);
            end
            sel_q   <= '0;
            state_q <= StMac;
          end
        end
        StMac: begin
          sum_q[sel_q] <= sum_q[sel_q] + SumW'(prod);
          if (sel_q == ColorSelW'(NumColors - 1)) begin
            sel_q <= '0;
            if (last_q) begin
              div_req_q <= 1'b1;
              state_q   <= StDiv;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            sel_q <= sel_q + ColorSelW'(1);
          end
        end
        StDiv: begin
          if (div_start) begin
            div_req_q <= 1'b0;
          end
          if (div_done) begin
            if (sel_q == ColorSelW'(NumColors - 1)) begin
              sel_q   <= '0;
              state_q <= StHold;
            end else begin
              sel_q     <= sel_q + ColorSelW'(1);
              div_req_q <= 1'b1;
            end
          end
        end
        StHold: begin
          if (load_out) begin
            weight_q    <= '0;
            flags_q     <= '1;
            started_q   <= 1'b0;
            run_len_q   <= '0;
            for (int i = 0; i < NumColors; i++) begin
              sum_q[i] <= '0;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q      <= w;
      last_q   <= ln.last_in_run;
      col_q[0] <= ln.line_red;
      col_q[1] <= ln.line_green;
      col_q[2] <= ln.line_blue;
      if (!started_q || ln.line_min < run_min_q) begin
        run_min_q <= ln.line_min;
      end
      if (!started_q || ln.line_max > run_max_q) begin
        run_max_q <= ln.line_max;
      end
    end
    if (state_q == StDiv && div_done) begin
      res_q[sel_q] <= (weight_q == '0) ? '0 : div_quot;
    end
    if (load_out) begin
      fold_q.fold_min   <= run_min_q;
      fold_q.fold_max   <= run_max_q;
      fold_q.fold_red   <= res_q[0];
      fold_q.fold_green <= res_q[1];
      fold_q.fold_blue  <= res_q[2];
      fold_q.fold_flags <= flags_q;
      fold_q.overrun    <= run_len_q > RunLenW'(MaxRun);
    end
  end

  assign line_i.ready = (state_q == StIdle);
  assign fold_o.valid = out_valid_q;
  assign fold_o.data  = fold_q;

  a_accept_to_mac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StMac && sel_q == '0)
    else $error("accepted line did not start accumulation");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider result outside the division phase");

  a_hold_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StHold && out_valid_q && !fold_o.ready |=> state_q == StHold)
    else $error("result overwrote a pending output");

  a_run_len_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_len_q <= RunLenW'(MaxRun + 1))
    else $error("run length passed its saturation value");

endmodule

### tb/wrf_fold_checker.sv
// Scoreboard for waveform_run_fold: watches the line and fold channels, folds
// each accepted line request into an expected result and checks results in order.
// Depends on wrf_pkg, wrf_line_if and wrf_fold_if.
module wrf_fold_checker
  import wrf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  wrf_line_if  line_i,
  wrf_fold_if  fold_o,
  output int   fail_cnt_o,
  output int   pend_cnt_o,
  output int   line_cnt_o,
  output int   fold_cnt_o,
  output int   overrun_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [SampleW-1:0] run_min;
  logic signed [SampleW-1:0] run_max;
  logic [SumW-1:0]           red_sum;
  logic [SumW-1:0]           green_sum;
  logic [SumW-1:0]           blue_sum;
  logic [WeightW-1:0]        weight_sum;
  logic [FlagW-1:0]          flag_and;
  logic                      run_started;
  logic [RunLenW-1:0]        run_len;
  fold_t                     expected_folds[$];

  int fail_cnt    = 0;
  int pend_cnt    = 0;
  int line_cnt    = 0;
  int fold_cnt    = 0;
  int overrun_cnt = 0;

  assign fail_cnt_o    = fail_cnt;
  assign pend_cnt_o    = pend_cnt;
  assign line_cnt_o    = line_cnt;
  assign fold_cnt_o    = fold_cnt;
  assign overrun_cnt_o = overrun_cnt;

  task automatic clear_run();
    run_min     = '0;
    run_max     = '0;
    red_sum     = '0;
    green_sum   = '0;
    blue_sum    = '0;
    weight_sum  = '0;
    flag_and    = '1;
    run_started = 1'b0;
    run_len     = '0;
  endtask

  function automatic logic [ColorW-1:0] avg_color(logic [SumW-1:0] csum);
    logic [SumW-1:0] quot;
    if (weight_sum == '0) return '0;
    quot = csum / {{(SumW-WeightW){1'b0}}, weight_sum};
    return quot[ColorW-1:0];
  endfunction

  // Peak magnitude weight, at least 1; color and weight sums wrap at their widths.
  task automatic fold_line(input line_t l);
    int              lo_mag;
    int              hi_mag;
    logic [SumW-1:0] w;
    fold_t           f;
    lo_mag = int'(l.line_min);
    hi_mag = int'(l.line_max);
    if (lo_mag < 0) lo_mag = -lo_mag;
    if (hi_mag < 0) hi_mag = -hi_mag;
    w = (lo_mag > hi_mag) ? lo_mag : hi_mag;
    if (w == '0) w = 1;
    if (!run_started) begin
      run_min     = l.line_min;
      run_max     = l.line_max;
      run_started = 1'b1;
    end else begin
      if (l.line_min < run_min) run_min = l.line_min;
      if (l.line_max > run_max) run_max = l.line_max;
    end
    red_sum    = red_sum + l.line_red * w;
    green_sum  = green_sum + l.line_green * w;
    blue_sum   = blue_sum + l.line_blue * w;
    weight_sum = weight_sum + w[WeightW-1:0];
    flag_and   = flag_and & l.line_flags;
    if (run_len <= MaxRun) run_len = run_len + 1'b1;
    line_cnt++;
    if (l.last_in_run) begin
      f.fold_min   = run_min;
      f.fold_max   = run_max;
      f.fold_red   = avg_color(red_sum);
      f.fold_green = avg_color(green_sum);
      f.fold_blue  = avg_color(blue_sum);
      f.fold_flags = flag_and;
      f.overrun    = (run_len > MaxRun);
      expected_folds.insert(expected_folds.size(), f);
      clear_run();
    end
  endtask

  task automatic check_fold(input fold_t got);
    fold_t want;
    fold_cnt++;
    if (got.overrun === 1'b1) overrun_cnt++;
    if (expected_folds.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: fold request with none expected: min %0d max %0d rgb %0d/%0d/%0d",
                 $realtime, got.fold_min, got.fold_max, got.fold_red, got.fold_green,
                 got.fold_blue);
    end else begin
      want = expected_folds.pop_front();
      if (got.fold_min !== want.fold_min || got.fold_max !== want.fold_max ||
          got.fold_red !== want.fold_red || got.fold_green !== want.fold_green ||
          got.fold_blue !== want.fold_blue || got.fold_flags !== want.fold_flags ||
          got.overrun !== want.overrun) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("%0t: fold mismatch", $realtime);
          $display("  expected min %0d max %0d rgb %0d/%0d/%0d flags %h overrun %b",
                   want.fold_min, want.fold_max, want.fold_red, want.fold_green,
                   want.fold_blue, want.fold_flags, want.overrun);
          $display("  actual   min %0d max %0d rgb %0d/%0d/%0d flags %h overrun %b",
                   got.fold_min, got.fold_max, got.fold_red, got.fold_green,
                   got.fold_blue, got.fold_flags, got.overrun);
        end
      end
    end
  endtask

  initial clear_run();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      expected_folds.delete();
    end else begin
      // older run first: a result never belongs to a line accepted at the same edge
      if (fold_o.valid === 1'b1 && fold_o.ready === 1'b1) check_fold(fold_o.data);
      if (line_i.valid === 1'b1 && line_i.ready === 1'b1) fold_line(line_i.data);
    end
    pend_cnt = expected_folds.size();
  end

endmodule

### tb/tb_waveform_run_fold.sv
// Top of the waveform_run_fold testbench: clock, reset, line requests and
// fold receiver with idling and back-pressure, verdict from wrf_fold_checker.
// Depends on wrf_pkg, wrf_line_if, wrf_fold_if, waveform_run_fold, wrf_fold_checker.
module tb_waveform_run_fold;
  timeunit 1ns;
  timeprecision 1ps;
  import wrf_pkg::*;

  logic clk;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_len      = 0;
  int   hold_grant    = 0;
  int   sent_cnt      = 0;
  int   fail_cnt;
  int   pend_cnt;
  int   line_cnt;
  int   fold_cnt;
  int   overrun_cnt;

  wrf_line_if line_bus ();
  wrf_fold_if fold_bus ();

  waveform_run_fold uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .line_i (line_bus),
    .fold_o (fold_bus)
  );

  wrf_fold_checker fold_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .line_i        (line_bus),
    .fold_o        (fold_bus),
    .fail_cnt_o    (fail_cnt),
    .pend_cnt_o    (pend_cnt),
    .line_cnt_o    (line_cnt),
    .fold_cnt_o    (fold_cnt),
    .overrun_cnt_o (overrun_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", pend_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // fold receiver; a hold-off, started by each new hold_grant and sized by hold_len, keeps ready low
  initial begin : recv_proc
    int served;
    served = 0;
    fold_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_grant != served) begin
        served = hold_grant;
        fold_bus.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
      end
      fold_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic line_t mk_line(int lo, int hi, int r, int g, int b, int fl, bit last);
    line_t l;
    l.line_min    = lo[SampleW-1:0];
    l.line_max    = hi[SampleW-1:0];
    l.line_red    = r[ColorW-1:0];
    l.line_green  = g[ColorW-1:0];
    l.line_blue   = b[ColorW-1:0];
    l.line_flags  = fl[FlagW-1:0];
    l.last_in_run = last;
    return l;
  endfunction

  function automatic int rand_sample();
    int pick;
    pick = $urandom_range(3);
    case (pick)
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(64) - 32;
      2: begin
        pick = $urandom_range(4);
        case (pick)
          0: return -32768;
          1: return 32767;
          2: return -1;
          3: return 1;
          default: return 0;
        endcase
      end
      default: return $urandom_range(1) ? $urandom_range(2000) : -$urandom_range(2000);
    endcase
  endfunction

  function automatic int rand_flags();
    if ($urandom_range(1)) return $urandom_range(255);
    return ~(1 << $urandom_range(7)) & 8'hff;
  endfunction

  function automatic line_t rand_line(bit last);
    int lo;
    int hi;
    int t;
    lo = rand_sample();
    hi = rand_sample();
    if (lo > hi && $urandom_range(3) != 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    return mk_line(lo, hi, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                   rand_flags(), last);
  endfunction

  // caller stands at a falling edge; returns at the falling edge after acceptance
  task automatic send_line(input line_t l);
    while ($urandom_range(99) < send_idle_pct) begin
      line_bus.valid <= 1'b0;
      @(negedge clk);
    end
    line_bus.valid <= 1'b1;
    line_bus.data  <= l;
    do @(posedge clk); while (line_bus.ready !== 1'b1);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_line(rand_line(i == len - 1));
  endtask

  // long runs around the overrun limit; peak weight 32768 x 512 wraps the weight sum to 0
  task automatic send_long(input int len, input bit wrap);
    line_t l;
    for (int i = 0; i < len; i++) begin
      l = rand_line(i == len - 1);
      l.line_flags = (i == len - 1) ? 8'h7e : 8'hff;
      if (wrap) begin
        l.line_min = SampleW'(-32768);
        l.line_max = '0;
      end
      send_line(l);
    end
  endtask

  task automatic random_phase(input int n_lines);
    int goal;
    int r;
    goal = sent_cnt + n_lines;
    while (sent_cnt < goal) begin
      r = $urandom_range(99);
      if (r < 30)      send_run(1);
      else if (r < 90) send_run($urandom_range(2, 6));
      else             send_run($urandom_range(7, 40));
    end
  endtask

  task automatic drain();
    line_bus.valid <= 1'b0;
    wait (pend_cnt == 0);
    @(negedge clk);
  endtask

  initial begin
    rst_n          = 1'b0;
    line_bus.valid = 1'b0;
    line_bus.data  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 49;
    // single-line and short runs: extremes, zero weight raised to 1, min above max
    send_line(mk_line(-32768, 32767, 255, 0, 128, 8'hff, 1'b1));
    send_line(mk_line(0, 0, 7, 200, 33, 8'h00, 1'b1));
    send_line(mk_line(32767, -32768, 1, 254, 127, 8'h80, 1'b1));
    send_line(mk_line(-1, 1, 0, 0, 0, 8'h01, 1'b1));
    send_line(mk_line(100, 200, 10, 20, 30, 8'hf0, 1'b0));
    send_line(mk_line(-32768, -1, 200, 100, 50, 8'h3c, 1'b0));
    send_line(mk_line(5, 32767, 255, 255, 255, 8'hff, 1'b1));
    send_line(mk_line(0, 0, 255, 0, 0, 8'hff, 1'b0));
    send_line(mk_line(0, 0, 0, 255, 0, 8'hfe, 1'b0));
    send_line(mk_line(0, 0, 0, 0, 255, 8'h55, 1'b1));
    send_line(mk_line(-20000, 30000, 3, 3, 3, 8'haa, 1'b0));
    send_line(mk_line(0, 1, 250, 250, 250, 8'hab, 1'b1));
    drain();
    send_long(MaxRun, 1'b0);
    send_long(2 * MaxRun, 1'b1);
    random_phase(45);
    drain();

    send_idle_pct = 49;
    recv_idle_pct = 25;
    random_phase(45);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len      = 800;
    hold_grant    = hold_grant + 1;
    for (int i = 0; i < 12; i++) send_run($urandom_range(1, 3));
    random_phase(40);

    drain();
    repeat (150) @(posedge clk);
    $display("Folded %0d line requests into %0d results (%0d with overrun),",
             line_cnt, fold_cnt, overrun_cnt);
    $display("with idling on both sides, a long receiver hold-off and runs past the limit.");
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
